[hdl/spectral_energy_beat_detector_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef SPECTRAL_ENERGY_BEAT_DETECTOR_MACROS_SVH
`define SPECTRAL_ENERGY_BEAT_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define SEBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sebd: same-cycle check failed");
`define SEBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sebd: next-cycle check failed");
`else
`define SEBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SEBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/sebd_pkg.sv]
package sebd_pkg;

  localparam int MaxBinsDef = 512;
  localparam int HistoryDef = 64;

  localparam int BinCntW  = 10;
  localparam int GainW    = 12;
  localparam int CfgDataW = 12;
  localparam int CfgIdxW  = 1;
  localparam int SampleW  = 16;
  localparam int EnergyW  = 17;
  localparam int OutW     = 32;
  localparam int AccW     = EnergyW + BinCntW;

  localparam logic [BinCntW-1:0] BinCountRst = 10'd64;
  localparam logic [GainW-1:0]   BeatGainRst = 12'd486;

  localparam logic [CfgIdxW-1:0] CfgBinCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBeatGain = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] bin_real;
    logic signed [SampleW-1:0] bin_imag;
  } bin_t;

  typedef struct packed {
    logic            beat;
    logic [OutW-1:0] frame_energy;
    logic [OutW-1:0] history_average;
  } res_t;

  function automatic logic [SampleW-1:0] mag_of(input logic signed [SampleW-1:0] x);
    logic [SampleW-1:0] m;
    m = x[SampleW-1] ? (~x + 1'b1) : x;
    return m;
  endfunction

endpackage

[hdl/sebd_stream_if.sv]
interface sebd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/spectral_energy_beat_detector.sv]
// Spectral energy beat detector.
// bin_i takes one complex spectrum bin per beat (signed Q1.15 real and imaginary parts).
// res_o gives one beat per frame: beat flag, frame energy and history average.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i: index 0 is
// bin_count, index 1 is beat_gain (Q4.8); write them only while the block is idle.
// Each bin is taken in the idle state, then makes four passes through the shared
// 23x16-bit multiplier (two squarings per part, then accumulate).
// The last bin of a frame then runs the shared restoring divider twice, one
// quotient bit per cycle over AccW (27) bits, plus the multiplier twice for the
// threshold compare; the first frame skips the average, so it runs the divider
// once and skips the compare.
// bin_i.ready is high only while the sequencer is idle.
// The result sits in an output register; the next bins are taken while it waits,
// and the sequencer holds in its update step only if a new result is due before
// res_o.ready has taken the previous one.
// Reset clears the accumulator, bin counter, history ring (valid bits), running
// sum and frame count, loads bin_count = 64 and beat_gain = 486, and empties res_o.
`include "spectral_energy_beat_detector_macros.svh"
module spectral_energy_beat_detector import sebd_pkg::*; #(
  parameter int MAX_BINS = MaxBinsDef,
  parameter int HISTORY  = HistoryDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sebd_stream_if.sink         bin_i,
  sebd_stream_if.source       res_o
);

  localparam int HistDepth = HISTORY - 1;
  localparam int CntHW     = $clog2(HISTORY);
  localparam int PtrW      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int WsW       = EnergyW + CntHW;
  localparam int MulAW     = WsW;
  localparam int MulBW     = SampleW;
  localparam int PW        = MulAW + MulBW;

  localparam logic [BinCntW-1:0] MaxBinsC =
    (MAX_BINS >= (1 << BinCntW)) ? {BinCntW{1'b1}} : BinCntW'(MAX_BINS);

  localparam int StW = 4;
  localparam logic [StW-1:0] S_IDLE  = 4'd0;
  localparam logic [StW-1:0] S_SQ_IM = 4'd1;
  localparam logic [StW-1:0] S_P4_RE = 4'd2;
  localparam logic [StW-1:0] S_P4_IM = 4'd3;
  localparam logic [StW-1:0] S_ACC   = 4'd4;
  localparam logic [StW-1:0] S_DIV_E = 4'd5;
  localparam logic [StW-1:0] S_DIV_A = 4'd6;
  localparam logic [StW-1:0] S_MUL_L = 4'd7;
  localparam logic [StW-1:0] S_MUL_R = 4'd8;
  localparam logic [StW-1:0] S_CMP   = 4'd9;
  localparam logic [StW-1:0] S_UPD   = 4'd10;

  logic [StW-1:0]     state_q, state_d;
  logic [BinCntW-1:0] bin_count_q;
  logic [GainW-1:0]   gain_q;
  logic [BinCntW-1:0] eff;

  logic [AccW-1:0]    acc_q, acc_d;
  logic [AccW-1:0]    acc_sum;
  logic [BinCntW-1:0] cnt_q, cnt_d;
  logic [BinCntW-1:0] cnt_inc;
  logic [WsW-1:0]     ws_q, ws_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [CntHW-1:0]   frames_q, frames_d;

  logic [SampleW-1:0] mag_im_q, mag_im_d;
  logic [14:0]        sq_re_q, sq_re_d;
  logic [14:0]        sq_im_q, sq_im_d;
  logic [EnergyW-1:0] energy_q, energy_d;
  logic [EnergyW-1:0] avg_q, avg_d;
  logic [PW-1:0]      lhs_q, lhs_d;
  logic               beat_q, beat_d;

  logic               out_vld_q, out_vld_d;
  res_t               out_q, out_d;
  logic               out_free;

  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [PW-1:0]      mul_p;
  logic [14:0]        sq_sat;
  logic [14:0]        p4;

  logic               div_start;
  logic [AccW-1:0]    div_num;
  logic [BinCntW-1:0] div_den;
  logic               div_busy;
  logic [AccW-1:0]    div_quo;

  logic               hist_we;
  logic [EnergyW-1:0] hist_old;

  sebd_mul #(
    .AW(MulAW),
    .BW(MulBW)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  sebd_div #(
    .NumW(AccW),
    .DenW(BinCntW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  sebd_hist #(
    .Depth(HistDepth),
    .AddrW(PtrW),
    .DataW(EnergyW)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .addr_i   (ptr_q),
    .wr_en_i  (hist_we),
    .wr_data_i(energy_q),
    .rd_data_o(hist_old)
  );

  always_comb begin
    if (bin_count_q == '0) begin
      eff = BinCntW'(1);
    end else if (bin_count_q > MaxBinsC) begin
      eff = MaxBinsC;
    end else begin
      eff = bin_count_q;
    end
  end

  assign sq_sat   = mul_p[30] ? 15'h7fff : mul_p[29:15];
  assign p4       = mul_p[29:15];
  assign acc_sum  = acc_q + AccW'(p4);
  assign cnt_inc  = cnt_q + 1'b1;
  assign out_free = !out_vld_q || res_o.ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        mul_a = MulAW'(mag_of(bin_i.data.bin_real));
        mul_b = mag_of(bin_i.data.bin_real);
      end
      S_SQ_IM: begin
        mul_a = MulAW'(mag_im_q);
        mul_b = mag_im_q;
      end
      S_P4_RE: begin
        mul_a = MulAW'(sq_re_q);
        mul_b = MulBW'(sq_re_q);
      end
      S_P4_IM: begin
        mul_a = MulAW'(sq_im_q);
        mul_b = MulBW'(sq_im_q);
      end
      S_MUL_L: begin
        mul_a = MulAW'(energy_q);
        mul_b = MulBW'(frames_q);
      end
      S_MUL_R: begin
        mul_a = ws_q;
        mul_b = MulBW'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    ws_d      = ws_q;
    ptr_d     = ptr_q;
    frames_d  = frames_q;
    mag_im_d  = mag_im_q;
    sq_re_d   = sq_re_q;
    sq_im_d   = sq_im_q;
    energy_d  = energy_q;
    avg_d     = avg_q;
    lhs_d     = lhs_q;
    beat_d    = beat_q;
    out_vld_d = out_vld_q && !res_o.ready;
    out_d     = out_q;
    div_start = 1'b0;
    div_num   = acc_sum;
    div_den   = eff;
    hist_we   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (bin_i.valid) begin
          mag_im_d = mag_of(bin_i.data.bin_imag);
          state_d  = S_SQ_IM;
        end
      end
      S_SQ_IM: begin
        sq_re_d = sq_sat;
        state_d = S_P4_RE;
      end
      S_P4_RE: begin
        sq_im_d = sq_sat;
        state_d = S_P4_IM;
      end
      S_P4_IM: begin
        acc_d   = acc_sum;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (cnt_inc == '0 || cnt_inc >= eff) begin
          div_start = 1'b1;
          acc_d     = '0;
          cnt_d     = '0;
          state_d   = S_DIV_E;
        end else begin
          acc_d   = acc_sum;
          cnt_d   = cnt_inc;
          state_d = S_IDLE;
        end
      end
      S_DIV_E: begin
        if (!div_busy) begin
          energy_d = div_quo[EnergyW-1:0];
          if (frames_q == '0) begin
            avg_d   = '0;
            beat_d  = 1'b0;
            state_d = S_UPD;
          end else begin
            div_start = 1'b1;
            div_num   = AccW'(ws_q);
            div_den   = BinCntW'(frames_q);
            state_d   = S_DIV_A;
          end
        end
      end
      S_DIV_A: begin
        if (!div_busy) begin
          avg_d   = div_quo[EnergyW-1:0];
          state_d = S_MUL_L;
        end
      end
      S_MUL_L: begin
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        lhs_d   = {mul_p[PW-9:0], 8'b0};
        state_d = S_CMP;
      end
      S_CMP: begin
        beat_d  = lhs_q > mul_p;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_vld_d             = 1'b1;
          out_d.beat            = beat_q;
          out_d.frame_energy    = OutW'(energy_q);
          out_d.history_average = OutW'(avg_q);
          hist_we               = 1'b1;
          ws_d                  = ws_q - WsW'(hist_old) + WsW'(energy_q);
          ptr_d = (ptr_q == PtrW'(HistDepth - 1)) ? '0 : ptr_q + 1'b1;
          if (frames_q != CntHW'(HistDepth)) begin
            frames_d = frames_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= BinCountRst;
      gain_q      <= BeatGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBinCount: bin_count_q <= cfg_wdata_i[BinCntW-1:0];
        CfgBeatGain: gain_q      <= cfg_wdata_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      ws_q      <= '0;
      ptr_q     <= '0;
      frames_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      ws_q      <= ws_d;
      ptr_q     <= ptr_d;
      frames_q  <= frames_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_im_q <= mag_im_d;
    sq_re_q  <= sq_re_d;
    sq_im_q  <= sq_im_d;
    energy_q <= energy_d;
    avg_q    <= avg_d;
    lhs_q    <= lhs_d;
    beat_q   <= beat_d;
    out_q    <= out_d;
  end

  assign bin_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  `SEBD_ASSERT_NEXT(a_accept_starts_bin, clk_i, rst_ni, bin_i.valid && bin_i.ready, state_q == S_SQ_IM)
  `SEBD_ASSERT_NOW(a_idle_div_quiet, clk_i, rst_ni, bin_i.ready, !div_busy)
  `SEBD_ASSERT_NOW(a_ptr_in_ring, clk_i, rst_ni, 1'b1, ptr_q <= PtrW'(HistDepth - 1))
  `SEBD_ASSERT_NEXT(a_update_loads, clk_i, rst_ni, state_q == S_UPD && out_free, res_o.valid && state_q == S_IDLE)

endmodule

[hdl/sebd_mul.sv]
module sebd_mul import sebd_pkg::*; #(
  parameter int AW = EnergyW + $clog2(HistoryDef),
  parameter int BW = SampleW
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hdl/sebd_div.sv]
module sebd_div import sebd_pkg::*; #(
  parameter int NumW = AccW,
  parameter int DenW = BinCntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    trial  = {rem_q, quo_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[hdl/sebd_hist.sv]
module sebd_hist import sebd_pkg::*; #(
  parameter int Depth = HistoryDef - 1,
  parameter int AddrW = $clog2(HistoryDef - 1),
  parameter int DataW = EnergyW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] addr_i,
  input  logic             wr_en_i,
  input  logic [DataW-1:0] wr_data_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [DataW-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[test/tb_spectral_energy_beat_detector.sv]
module tb_spectral_energy_beat_detector;
  import sebd_pkg::*;

  localparam int HistDepth   = HistoryDef - 1;
  localparam int DrainCycles = 80;
  localparam int StallLimit  = 4000;

  typedef enum logic {RowBin, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    bin_t                b;
    logic [6:0]          reps;
    logic                typed;
    res_t                want;
  } step_t;

  typedef struct packed {
    logic [CfgDataW-1:0] bin_count;
    logic [CfgDataW-1:0] gain;
    logic [9:0]          n_bins;
  } phase_t;

  localparam step_t Plan [18] = '{
    '{RowBin, CfgBinCount, 12'd0, '{16'sh8000, 16'sh8000}, 7'd64, 1'b1,
      '{1'b0, 32'd65532, 32'd0}},
    '{RowReg, CfgBinCount, 12'd1, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sd0, 16'sd0}, 7'd1, 1'b1,
      '{1'b0, 32'd0, 32'd65532}},
    '{RowBin, CfgBinCount, 12'd0, '{16'sh7FFF, 16'sh7FFF}, 7'd1, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{-16'sd1, 16'sd1}, 7'd1, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sh7FFF, 16'sh8000}, 7'd1, 1'b0, '0},
    '{RowReg, CfgBeatGain, 12'd0, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sh8000, 16'sd0}, 7'd1, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sd0, 16'sd0}, 7'd1, 1'b0, '0},
    '{RowReg, CfgBeatGain, 12'hFFF, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sh8000, 16'sh8000}, 7'd1, 1'b0, '0},
    '{RowReg, CfgBinCount, 12'd0, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sd16384, -16'sd16384}, 7'd1, 1'b0, '0},
    '{RowReg, CfgBinCount, 12'hC03, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sd12345, -16'sd23456}, 7'd2, 1'b0, '0},
    '{RowReg, CfgBinCount, 12'd2, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0},
    '{RowBin, CfgBinCount, 12'd0, '{16'sh8000, 16'sh7FFF}, 7'd1, 1'b0, '0},
    '{RowReg, CfgBeatGain, 12'd486, '{16'sd0, 16'sd0}, 7'd0, 1'b0, '0}
  };

  localparam phase_t Phases [4] = '{
    '{12'd3, 12'd486, 10'd60},
    '{12'd1, 12'd256, 10'd60},
    '{12'h3FF, 12'hFFF, 10'd512},
    '{12'd2, 12'd384, 10'd40}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sebd_stream_if #(.T(bin_t)) bin_if ();
  sebd_stream_if #(.T(res_t)) res_if ();

  spectral_energy_beat_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bin_i       (bin_if),
    .res_o       (res_if)
  );

  logic [BinCntW-1:0] bin_count_q = BinCountRst;
  logic [GainW-1:0]   gain_q      = BeatGainRst;
  logic [47:0]        energy_acc  = '0;
  logic [9:0]         bins_in_frame = '0;
  logic [31:0]        energy_ring [HistDepth] = '{default: '0};
  int unsigned        ring_ptr = 0;
  logic [37:0]        ring_sum = '0;
  int unsigned        frames_logged = 0;

  res_t frame_q [$];
  int   fails = 0;
  int   src_idle_pct = 24;
  int   snk_idle_pct = 66;
  int   stall_cycles = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [31:0] quartic_q15(input logic signed [15:0] x);
    longint unsigned mag;
    longint unsigned sq;
    mag = (x < 0) ? longint'(-int'(x)) : longint'(x);
    sq = (mag * mag) >> 15;
    if (sq > 32767) sq = 32767;
    return 32'((sq * sq) >> 15);
  endfunction

  function automatic bit fold_bin(input bin_t b, output res_t r);
    int unsigned eff;
    int unsigned cnt;
    logic [31:0] energy;
    logic [31:0] old;
    logic [63:0] lhs;
    logic [63:0] rhs;
    r = '0;
    eff = bin_count_q;
    if (eff == 0) eff = 1;
    if (eff > MaxBinsDef) eff = MaxBinsDef;
    energy_acc = energy_acc + 48'(quartic_q15(b.bin_real)) + 48'(quartic_q15(b.bin_imag));
    bins_in_frame = bins_in_frame + 10'd1;
    if (bins_in_frame != 0 && bins_in_frame < eff) return 1'b0;
    energy = 32'(energy_acc / 48'(eff));
    energy_acc = '0;
    bins_in_frame = '0;
    cnt = (frames_logged < HistDepth) ? frames_logged : HistDepth;
    r.frame_energy = energy;
    if (cnt != 0) begin
      r.history_average = 32'(ring_sum / 38'(cnt));
      lhs = 64'(energy) * 64'(cnt) * 64'd256;
      rhs = 64'(gain_q) * 64'(ring_sum);
      r.beat = lhs > rhs;
    end
    old = energy_ring[ring_ptr];
    ring_sum = ring_sum - 38'(old) + 38'(energy);
    energy_ring[ring_ptr] = energy;
    ring_ptr = (ring_ptr + 1) % HistDepth;
    if (frames_logged < HistDepth) frames_logged++;
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] rand_part();
    logic signed [15:0] v;
    int unsigned sel;
    v = 16'($urandom);
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(3))
        0: v = 16'sh8000;
        1: v = 16'sh7FFF;
        2: v = '0;
        default: v = '1;
      endcase
    end else if (sel > 3) begin
      v = v >>> $urandom_range(1, 13);
    end
    return v;
  endfunction

  task automatic drain();
    bin_if.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgBinCount: bin_count_q = data[BinCntW-1:0];
      CfgBeatGain: gain_q = data[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_bin(input bin_t b, input logic typed, input res_t want);
    res_t got;
    if ($urandom_range(99) < src_idle_pct) begin
      bin_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    bin_if.valid <= 1'b1;
    bin_if.data  <= b;
    do @(posedge clk_i); while (!bin_if.ready);
    if (fold_bin(b, got)) frame_q.push_back(typed ? want : got);
  endtask

  always @(posedge clk_i) begin
    res_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : check_frames
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (frame_q.size() == 0) begin
        $error("frame result with none expected");
        fails++;
      end else begin
        want = frame_q.pop_front();
        if (res_if.data.beat !== want.beat) begin
          $error("beat: expected %0d, got %0d", want.beat, res_if.data.beat);
          fails++;
        end
        if (res_if.data.frame_energy !== want.frame_energy) begin
          $error("frame_energy: expected %0d, got %0d", want.frame_energy,
                 res_if.data.frame_energy);
          fails++;
        end
        if (res_if.data.history_average !== want.history_average) begin
          $error("history_average: expected %0d, got %0d", want.history_average,
                 res_if.data.history_average);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bin_t b;
    int   total;
    int   n;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    bin_if.valid <= 1'b0;
    bin_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(Plan); i++) begin
      if (Plan[i].kind == RowReg) begin
        write_reg(Plan[i].idx, Plan[i].wdata);
      end else begin
        for (int r = 0; r < Plan[i].reps; r++) send_bin(Plan[i].b, Plan[i].typed, Plan[i].want);
      end
    end

    total = 0;
    foreach (Phases[p]) total += Phases[p].n_bins;
    n = 0;
    foreach (Phases[p]) begin
      write_reg(CfgBinCount, Phases[p].bin_count);
      write_reg(CfgBeatGain, Phases[p].gain);
      for (int k = 0; k < Phases[p].n_bins; k++) begin
        if (n < total / 3) begin
          src_idle_pct = 24;
          snk_idle_pct = 66;
        end else if (n < 2 * total / 3) begin
          src_idle_pct = 66;
          snk_idle_pct = 24;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        b.bin_real = rand_part();
        b.bin_imag = rand_part();
        send_bin(b, 1'b0, '0);
        n++;
      end
    end

    drain();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/sebd_pkg.sv
hdl/sebd_stream_if.sv
hdl/sebd_mul.sv
hdl/sebd_div.sv
hdl/sebd_hist.sv
hdl/spectral_energy_beat_detector.sv
test/tb_spectral_energy_beat_detector.sv
